[sv/tmcr_pkg.sv]
// ----------------------------------------------------------------------------
// tmcr_pkg
// Shared types and constants of the tile map collision resolver.
// ----------------------------------------------------------------------------
package tmcr_pkg;

  localparam int unsigned MapCols    = 256;
  localparam int unsigned MapRows    = 128;
  localparam int unsigned TilePixels = 32;
  localparam int unsigned ColW       = $clog2(MapCols);
  localparam int unsigned RowW       = $clog2(MapRows);
  localparam int unsigned AddrW      = ColW + RowW;
  localparam int unsigned TileSh     = $clog2(TilePixels);
  localparam int unsigned QDepth     = 2;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_RESOLVE = 1'b1
  } cmd_e;

  // one decoded word handed from the front to the back
  typedef struct packed {
    cmd_e              cmd;
    logic [6:0]        tile_row;
    logic [7:0]        tile_col;
    logic [7:0]        tile_value;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]        box_width;
    logic [7:0]        box_height;
    logic signed [7:0] step_x;
    logic signed [7:0] step_y;
    logic              in_map;
  } work_t;

  // truncating divide by the tile size (toward zero), 24-bit signed value
  function automatic logic signed [23:0] tdiv(input logic signed [23:0] v);
    logic signed [23:0] a;
    begin
      a = v + ((v < 0) ? 24'(TilePixels - 1) : 24'sd0);
      tdiv = a >>> TileSh;
    end
  endfunction

endpackage

[sv/tmcr_front.sv]
// ----------------------------------------------------------------------------
// tmcr_front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tmcr_front import tmcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [6:0]         tile_row_i,
  input  logic [7:0]         tile_col_i,
  input  logic [7:0]         tile_value_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [7:0]         box_width_i,
  input  logic [7:0]         box_height_i,
  input  logic signed [7:0]  step_x_i,
  input  logic signed [7:0]  step_y_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output work_t              q_word_o
);

  work_t      fifo_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  work_t      wr;
  logic       push, pop;

  // classify: tag map writes that land inside the map
  always_comb begin
    wr.cmd        = cmd_e'(command_i);
    wr.tile_row   = tile_row_i;
    wr.tile_col   = tile_col_i;
    wr.tile_value = tile_value_i;
    wr.pos_x      = pos_x_i;
    wr.pos_y      = pos_y_i;
    wr.box_width  = box_width_i;
    wr.box_height = box_height_i;
    wr.step_x     = step_x_i;
    wr.step_y     = step_y_i;
    wr.in_map     = (32'(tile_row_i) < MapRows) && (32'(tile_col_i) < MapCols);
  end

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_word_o   = fifo_q[rp_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= wr;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(QDepth) |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
`endif

endmodule

[sv/tmcr_back.sv]
// ----------------------------------------------------------------------------
// tmcr_back
// Executes queued words: map writes and the two-pass box sweep.
// ----------------------------------------------------------------------------
module tmcr_back import tmcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         blank_threshold_i,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  work_t              q_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [7:0]  out_step_x_o,
  output logic signed [7:0]  out_step_y_o,
  output logic               on_ground_o,
  output logic               fell_out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_HADDR, S_HTEST, S_VADDR, S_VTEST, S_FIN, S_OUT
  } state_e;

  localparam logic signed [23:0] T24 = 24'(TilePixels);
  localparam logic signed [23:0] C24 = 24'(MapCols);
  localparam logic signed [23:0] R24 = 24'(MapRows);

  logic [7:0] mem [MapCols * MapRows];

  state_e             st_q;
  logic signed [23:0] x_q, y_q, w_q, h_q, dx_q, dy_q, i_q;
  logic               gnd_q;
  logic [ColW-1:0]    ext_c_q;
  logic [RowW-1:0]    ext_r_q;
  logic signed [23:0] c1_q, c2_q, r1_q, r2_q;
  logic               ok_q;
  logic               va_q, vb_q;
  logic [7:0]         rd_a_q, rd_b_q;
  logic [AddrW-1:0]   ad_a, ad_b;
  logic               sol_a, sol_b;
  logic signed [15:0] ox_q, oy_q;
  logic signed [7:0]  osx_q, osy_q;
  logic               ogd_q, ofo_q, ov_q;
  logic signed [23:0] c1, c2, r1, r2, inext, fx, fy, mx, my;
  logic               okc;
  logic               va, vb;

  assign q_ready_o   = (st_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_step_x_o = osx_q;
  assign out_step_y_o = osy_q;
  assign on_ground_o = ogd_q;
  assign fell_out_o  = ofo_q;

  // tile spans of the current slice
  always_comb begin
    if (st_q == S_HADDR) begin
      c1 = tdiv(x_q + dx_q);
      c2 = tdiv(x_q + dx_q + w_q - 24'sd1);
      r1 = tdiv(y_q);
      r2 = tdiv(y_q + i_q - 24'sd1);
    end else begin
      c1 = tdiv(x_q);
      c2 = tdiv(x_q + i_q);
      r1 = tdiv(y_q + dy_q);
      r2 = tdiv(y_q + dy_q + h_q);
    end
    okc = (c1 >= 0) && (c2 < C24) && (r1 >= 0) && (r2 < R24);
    // an empty box edge can put the far span one tile before the map; no tile there
    va  = !(st_q == S_HADDR && dx_q > 0) || (c2 >= 0);
    vb  = va && (r2 >= 0);
  end

  // read addresses chosen per pass and direction
  always_comb begin
    ad_a = '0;
    ad_b = '0;
    if (st_q == S_HADDR) begin
      ad_a = {r1[RowW-1:0], (dx_q > 0) ? c2[ColW-1:0] : c1[ColW-1:0]};
      ad_b = {r2[RowW-1:0], (dx_q > 0) ? c2[ColW-1:0] : c1[ColW-1:0]};
    end else begin
      ad_a = {(dy_q > 0) ? r2[RowW-1:0] : r1[RowW-1:0], c1[ColW-1:0]};
      ad_b = {(dy_q > 0) ? r2[RowW-1:0] : r1[RowW-1:0], c2[ColW-1:0]};
    end
  end

  assign sol_a = va_q && (rd_a_q > blank_threshold_i);
  assign sol_b = vb_q && (rd_b_q > blank_threshold_i);

  // slice stepping and final move
  always_comb begin
    inext = ((i_q + T24) > ((st_q == S_HTEST) ? h_q : w_q)) ?
            ((st_q == S_HTEST) ? h_q : w_q) : (i_q + T24);
    fx = x_q + dx_q;
    fy = y_q + dy_q;
    mx = (24'(ext_c_q) + 24'sd1) * T24;
    my = (24'(ext_r_q) + 24'sd1) * T24;
  end

  // tile store, two read ports and one write port
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i && !ov_q && q_word_i.cmd == CMD_WRITE &&
        q_word_i.in_map) begin
      mem[{q_word_i.tile_row[RowW-1:0], q_word_i.tile_col[ColW-1:0]}] <= q_word_i.tile_value;
    end
    rd_a_q <= mem[ad_a];
    rd_b_q <= mem[ad_b];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      ov_q    <= 1'b0;
      ext_c_q <= '0;
      ext_r_q <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (ov_q && out_ready_i) ov_q <= 1'b0;
          if (q_valid_i && !ov_q) begin
            if (q_word_i.cmd == CMD_WRITE) begin
              if (q_word_i.in_map && q_word_i.tile_value != 8'd0) begin
                if (q_word_i.tile_col[ColW-1:0] > ext_c_q)
                  ext_c_q <= q_word_i.tile_col[ColW-1:0];
                if (q_word_i.tile_row[RowW-1:0] > ext_r_q)
                  ext_r_q <= q_word_i.tile_row[RowW-1:0];
              end
              ox_q <= '0; oy_q <= '0; osx_q <= '0; osy_q <= '0;
              ogd_q <= 1'b0; ofo_q <= 1'b0; ov_q <= 1'b1;
            end else begin
              x_q  <= 24'(q_word_i.pos_x);
              y_q  <= 24'(q_word_i.pos_y);
              w_q  <= 24'({1'b0, q_word_i.box_width});
              h_q  <= 24'({1'b0, q_word_i.box_height});
              dx_q <= 24'(q_word_i.step_x);
              dy_q <= 24'(q_word_i.step_y);
              i_q  <= ({16'd0, q_word_i.box_height} > T24) ? T24 :
                      24'({1'b0, q_word_i.box_height});
              gnd_q <= 1'b0;
              st_q <= S_HADDR;
            end
          end
        end
        S_HADDR, S_VADDR: begin
          c1_q <= c1; c2_q <= c2; r1_q <= r1; r2_q <= r2; ok_q <= okc;
          va_q <= va; vb_q <= vb;
          st_q <= (st_q == S_HADDR) ? S_HTEST : S_VTEST;
        end
        S_HTEST: begin
          if (ok_q && dx_q > 0 && (sol_a || sol_b)) begin
            x_q <= 24'(c2_q * T24) - (w_q + 24'sd1);
            dx_q <= '0;
          end else if (ok_q && dx_q < 0 && (sol_a || sol_b)) begin
            x_q <= 24'((c1_q + 24'sd1) * T24);
            dx_q <= '0;
          end
          if (i_q == h_q) begin
            i_q <= (w_q > T24) ? T24 : w_q;
            st_q <= S_VADDR;
          end else begin
            i_q <= inext;
            st_q <= S_HADDR;
          end
        end
        S_VTEST: begin
          if (ok_q && dy_q > 0 && (sol_a || sol_b)) begin
            y_q <= 24'(r2_q * T24) - h_q;
            dy_q <= '0;
            gnd_q <= 1'b1;
          end else if (ok_q && dy_q < 0 && (sol_a || sol_b)) begin
            y_q <= 24'((r1_q + 24'sd1) * T24);
            dy_q <= '0;
          end
          if (i_q == w_q) begin
            st_q <= S_FIN;
          end else begin
            i_q <= inext;
            st_q <= S_VADDR;
          end
        end
        S_FIN: begin
          if (fx < 0) x_q <= '0;
          else if (fx + w_q >= mx) x_q <= mx - w_q - 24'sd1;
          else x_q <= fx;
          y_q <= fy;
          st_q <= S_OUT;
        end
        S_OUT: begin
          ox_q  <= (x_q > 24'sd32767) ? 16'sh7fff :
                   (x_q < -24'sd32768) ? 16'sh8000 : x_q[15:0];
          oy_q  <= (y_q > 24'sd32767) ? 16'sh7fff :
                   (y_q < -24'sd32768) ? 16'sh8000 : y_q[15:0];
          osx_q <= dx_q[7:0];
          osy_q <= dy_q[7:0];
          ogd_q <= gnd_q;
          ofo_q <= (y_q > my);
          ov_q  <= 1'b1;
          st_q  <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !q_ready_o) else $error("pop while busy");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_OUT |=> ov_q) else $error("result lost");
`endif

endmodule

[sv/tile_map_collision_resolver.sv]
// ----------------------------------------------------------------------------
// tile_map_collision_resolver
// Box versus tile map collision, horizontal then vertical pass.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word: a tile write
//   (command 0) or a box resolve (command 1). Every word yields one result
//   word on the output channel (out_valid_o/out_ready_i); writes give zeros.
//   blank_threshold is written through cfg_we_i/cfg_wdata_i; the user must
//   write it only while idle, as the block itself does not enforce this.
//   A two-entry queue sits between the front end and the executing back end.
//   A resolve reads the two-port tile store once per slice in each pass, so
//   its run time grows with the box height and width. The back end handles
//   one word at a time and accepts the next one in the cycle after the
//   result is taken.
//   A stalled receiver holds the result register and the back end, then the
//   queue fills and in_ready_o drops.
//   Reset clears the extent, threshold and control; tile contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module tile_map_collision_resolver import tmcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [6:0]         tile_row_i,
  input  logic [7:0]         tile_col_i,
  input  logic [7:0]         tile_value_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [7:0]         box_width_i,
  input  logic [7:0]         box_height_i,
  input  logic signed [7:0]  step_x_i,
  input  logic signed [7:0]  step_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [7:0]  out_step_x_o,
  output logic signed [7:0]  out_step_y_o,
  output logic               on_ground_o,
  output logic               fell_out_o
);

  logic [7:0] thr_q;
  logic       qv, qr;
  work_t      qw;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= '0;
    else if (cfg_we_i) thr_q <= cfg_wdata_i;
  end

  tmcr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .tile_row_i,
    .tile_col_i, .tile_value_i, .pos_x_i, .pos_y_i, .box_width_i,
    .box_height_i, .step_x_i, .step_y_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_word_o(qw)
  );

  tmcr_back u_back (
    .clk_i, .rst_ni, .blank_threshold_i(thr_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_word_i(qw),
    .out_valid_o, .out_ready_i, .out_x_o, .out_y_o, .out_step_x_o,
    .out_step_y_o, .on_ground_o, .fell_out_o
  );

endmodule
